### rtl/assert_macros.svh
// Assertion macros shared by the translation buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked only while out of reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error(msg);
// Property checked at every edge, reset included.
`define ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ANY(label, clk, prop, msg)
`endif
`endif

### rtl/tfr_pkg.sv
// Types and constants shared by the translation buffer modules.
package tfr_pkg;

  localparam int unsigned PageFieldW  = 16;
  localparam int unsigned FrameFieldW = 16;
  localparam int unsigned HitCountW   = 32;

  typedef enum logic [0:0] {
    ACT_LOOKUP = 1'b0,
    ACT_UPDATE = 1'b1
  } action_e;

  typedef struct packed {
    logic                   action;
    logic [PageFieldW-1:0]  virt_page;
    logic [FrameFieldW-1:0] new_frame;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic [FrameFieldW-1:0] phys_frame;
    logic [HitCountW-1:0]   hit_total;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_ACCESS,
    S_LOAD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic match;
    logic access;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_update;
  } sts_t;

endpackage

### rtl/tfr_ctrl.sv
// Request sequencer for the translation buffer.
`include "assert_macros.svh"
module tfr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tfr_pkg::cmd_t cmd_o,
  input  tfr_pkg::sts_t sts_i
);
  import tfr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_MATCH;
      end
      S_MATCH:  state_d = S_ACCESS;
      S_ACCESS: state_d = sts_i.is_update ? S_IDLE : S_LOAD;
      S_LOAD: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_MATCH:  cmd_o.match  = 1'b1;
      S_ACCESS: cmd_o.access = 1'b1;
      S_LOAD:   cmd_o.load   = out_free;
      default:  cmd_o = '0;
    endcase
  end

  // Set on load, drop once the receiver takes the result.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_RST(a_accept_to_match, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q == S_MATCH, "accepted request did not enter match")
  `ASSERT_RST(a_rise_from_load, clk_i, rst_ni, $rose(out_valid_o) |-> $past(state_q == S_LOAD), "result raised outside load")
  `ASSERT_ANY(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

### rtl/tfr_datapath.sv
// Entry tables, match logic, hit counter and result register.
`include "assert_macros.svh"
module tfr_datapath #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 16,
  parameter int unsigned FRAME_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tfr_pkg::req_t req_i,
  input  tfr_pkg::cmd_t cmd_i,
  output tfr_pkg::sts_t sts_o,
  output tfr_pkg::rsp_t rsp_o
);
  import tfr_pkg::*;

  localparam int unsigned IdxW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  // Captured request.
  logic                  act_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [FRAME_BITS-1:0] frame_q;

  // Entry storage.
  logic [TLB_ENTRIES-1:0] valid_q;
  logic [PAGE_BITS-1:0]   page_tab_q [TLB_ENTRIES];
  logic [FRAME_BITS-1:0]  frame_mem  [TLB_ENTRIES];
  logic [IdxW-1:0]        ptr_q;
  logic [HitCountW-1:0]   cnt_q;

  // Match results and frame read data.
  logic [TLB_ENTRIES-1:0] match_vec;
  logic [IdxW-1:0]        match_idx;
  logic                   hit_q;
  logic [IdxW-1:0]        idx_q;
  logic [FRAME_BITS-1:0]  rd_q;

  logic [PAGE_BITS+PageFieldW-1:0]   page_ext;
  logic [FRAME_BITS+FrameFieldW-1:0] frame_ext;
  logic [FrameFieldW+FRAME_BITS-1:0] rd_ext;
  logic [IdxW-1:0]                   wr_idx;
  logic [IdxW-1:0]                   ptr_next;
  logic                              do_write;
  rsp_t                              rsp_q;

  assign page_ext  = {{PAGE_BITS{1'b0}}, req_i.virt_page};
  assign frame_ext = {{FRAME_BITS{1'b0}}, req_i.new_frame};
  assign rd_ext    = {{FrameFieldW{1'b0}}, rd_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= req_i.action;
      page_q  <= page_ext[PAGE_BITS-1:0];
      frame_q <= frame_ext[FRAME_BITS-1:0];
    end
  end

  // Compare every entry; the lowest matching one wins.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (page_tab_q[i] == page_q);
    end
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) match_idx = IdxW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) begin
      hit_q <= |match_vec;
      idx_q <= match_idx;
    end
  end

  // Update in place on a hit, else fill at the round-robin pointer.
  assign do_write = cmd_i.access && (act_q == ACT_UPDATE);
  assign wr_idx   = hit_q ? idx_q : ptr_q;
  assign ptr_next = (ptr_q == IdxW'(TLB_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      frame_mem[wr_idx] <= frame_q;
    end
    if (cmd_i.access) begin
      rd_q <= frame_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write && !hit_q) begin
      page_tab_q[ptr_q] <= page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else begin
      if (do_write && !hit_q) begin
        valid_q[ptr_q] <= 1'b1;
        ptr_q          <= ptr_next;
      end
      if (cmd_i.access && (act_q == ACT_LOOKUP) && hit_q && (cnt_q != '1)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rsp_q.hit        <= hit_q;
      rsp_q.phys_frame <= hit_q ? rd_ext[FrameFieldW-1:0] : '0;
      rsp_q.hit_total  <= cnt_q;
    end
  end

  assign sts_o.is_update = (act_q == ACT_UPDATE);
  assign rsp_o           = rsp_q;

  `ASSERT_RST(a_cnt_monotonic, clk_i, rst_ni, cnt_q >= $past(cnt_q), "hit counter went down")
  `ASSERT_RST(a_ptr_range, clk_i, rst_ni, ({1'b0, ptr_q} < (IdxW+1)'(TLB_ENTRIES)), "pointer past last entry")
  `ASSERT_RST(a_valid_sticky, clk_i, rst_ni, (valid_q & $past(valid_q)) == $past(valid_q), "valid bit cleared")

endmodule

### rtl/tlb_fifo_replacement_unit.sv
// Top level of the fully associative translation buffer with round-robin fill.
// Usage:
//   Requests arrive on in_valid_i/in_ready_o with payload in_req_i. A lookup
//   request (action 0) searches all valid entries for the virtual page; an
//   update request (action 1) rewrites the frame of a matching entry, or installs
//   page and frame at the round-robin pointer and advances it.
//   Only lookups produce a result on out_valid_o/out_ready_i (out_rsp_o):
//   hit flag, frame (zero on a miss) and the saturating count of hits.
// Timing:
//   One request is in flight at a time, walked through match, access and
//   load steps by the sequencer. A lookup result is registered in the load
//   step; an update returns to idle after its access step, and the next
//   request is taken only once the sequencer is back in idle. The registered
//   read of the frame memory sets the extra load step of a lookup.
// Stalls:
//   The result sits in an output register. A new request may be taken
//   while it waits; the next lookup holds in its load step until the
//   receiver takes the pending result.
// Reset:
//   Asynchronous, active low: clears every valid bit, the pointer, the hit
//   count and the result valid. Entry page and frame storage is not cleared.
module tlb_fifo_replacement_unit #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 16,
  parameter int unsigned FRAME_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tfr_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tfr_pkg::rsp_t out_rsp_o
);
  import tfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accepts a request, steps it through, owns result valid.
  tfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: entry tables, match, counter and result register.
  tfr_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for the FIFO-replacement translation buffer.
module testbench;
  import tfr_pkg::*;

  localparam int unsigned NumEntries  = 16;
  localparam int unsigned MaxReported = 10;
  localparam int unsigned RandomReqs  = 850;

  // Scoreboard: mirror the buffer contents and queue the expected lookup results.
  class tlb_scoreboard;
    bit                   entry_live [NumEntries];
    bit [PageFieldW-1:0]  entry_vpn  [NumEntries];
    bit [FrameFieldW-1:0] entry_pfn  [NumEntries];
    int unsigned          fill_ptr;
    bit [HitCountW-1:0]   hits_seen;
    rsp_t                 pending_rsp[$];
    int unsigned          error_count;

    // Update the mirror for one accepted request; queue a result for a lookup.
    function void note_request(req_t req);
      int   slot;
      rsp_t exp_rsp;
      slot = -1;
      for (int i = NumEntries - 1; i >= 0; i--) begin
        if (entry_live[i] && entry_vpn[i] == req.virt_page) slot = i;
      end
      if (action_e'(req.action) == ACT_UPDATE) begin
        if (slot >= 0) begin
          entry_pfn[slot] = req.new_frame;
        end else begin
          entry_vpn[fill_ptr]  = req.virt_page;
          entry_pfn[fill_ptr]  = req.new_frame;
          entry_live[fill_ptr] = 1'b1;
          fill_ptr = (fill_ptr + 1) % NumEntries;
        end
      end else begin
        if (slot >= 0) begin
          if (hits_seen != '1) hits_seen++;
          exp_rsp.hit        = 1'b1;
          exp_rsp.phys_frame = entry_pfn[slot];
        end else begin
          exp_rsp.hit        = 1'b0;
          exp_rsp.phys_frame = '0;
        end
        exp_rsp.hit_total = hits_seen;
        pending_rsp.push_back(exp_rsp);
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_response(rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported)
          $display("unexpected result: hit=%0b frame=%h hit_total=%0d",
                   got.hit, got.phys_frame, got.hit_total);
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.hit != exp_rsp.hit || got.phys_frame != exp_rsp.phys_frame ||
          got.hit_total != exp_rsp.hit_total) begin
        error_count++;
        if (error_count <= MaxReported)
          $display("mismatch: exp hit=%0b frame=%h total=%0d, got hit=%0b frame=%h total=%0d",
                   exp_rsp.hit, exp_rsp.phys_frame, exp_rsp.hit_total,
                   got.hit, got.phys_frame, got.hit_total);
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  tlb_scoreboard sb = new;

  // Zero gaps run in bursts so that back-to-back traffic also gets covered.
  int unsigned send_burst_left = 0;
  int unsigned recv_burst_left = 0;

  tlb_fifo_replacement_unit #(
    .TLB_ENTRIES(NumEntries),
    .PAGE_BITS  (PageFieldW),
    .FRAME_BITS (FrameFieldW)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pick an idle length: mostly none or short, a few long.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one request: idle first, then hold valid and payload until accepted.
  // Leave valid high after acceptance so a zero gap on the next call
  // only swaps the payload at that same edge.
  task automatic send_request(input action_e act, input logic [PageFieldW-1:0] page,
                              input logic [FrameFieldW-1:0] frame);
    int unsigned gap;
    req_t        req;
    if (send_burst_left > 0) begin
      send_burst_left--;
      gap = 0;
    end else begin
      gap = idle_gap();
      if ($urandom_range(0, 49) == 0) send_burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.action    = act;
    req.virt_page = page;
    req.new_frame = frame;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Monitor: take requests and results as seen at each edge, before the
  // design's own updates of that edge land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_req_i);
      if (out_valid_o && out_ready_i) sb.check_response(out_rsp_o);
    end
  end

  // Receiver: stall at random, with occasional long stretches of steady ready.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (recv_burst_left > 0) begin
        recv_burst_left--;
        stall = 0;
      end else begin
        stall = idle_gap();
        if ($urandom_range(0, 19) == 0) recv_burst_left = $urandom_range(5, 20);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("tlb_fifo_replacement_unit test failed");
    $finish;
  end

  initial begin
    logic [PageFieldW-1:0] page_pool[24];
    logic [PageFieldW-1:0] page;
    int unsigned           pool_size;
    action_e               act;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty lookup, both page and frame extremes, in-place update.
    send_request(ACT_LOOKUP, 16'h0000, 16'hFFFF);
    send_request(ACT_UPDATE, 16'h0000, 16'hFFFF);
    send_request(ACT_LOOKUP, 16'h0000, 16'h0000);
    send_request(ACT_UPDATE, 16'hFFFF, 16'h0000);
    send_request(ACT_LOOKUP, 16'hFFFF, 16'hFFFF);
    send_request(ACT_UPDATE, 16'h0000, 16'h1234);
    send_request(ACT_LOOKUP, 16'h0000, 16'h0000);
    // Miss after hits: count must repeat unchanged.
    send_request(ACT_LOOKUP, 16'h8000, 16'h0000);
    // Fill the remaining entries, then install once more to wrap the pointer
    // and evict the oldest entry (page zero).
    for (int i = 0; i < NumEntries - 2; i++)
      send_request(ACT_UPDATE, 16'h0100 + 16'(i), 16'hA000 + 16'(i));
    send_request(ACT_UPDATE, 16'h5555, 16'hAAAA);
    send_request(ACT_LOOKUP, 16'h0000, 16'h0000);
    send_request(ACT_LOOKUP, 16'hFFFF, 16'h0000);

    // Random: draw most pages from a small pool so that hits, in-place
    // updates and evictions dominate; the rest are full-range noise.
    foreach (page_pool[i]) page_pool[i] = 16'($urandom);
    for (int i = 0; i < RandomReqs; i++) begin
      pool_size = (i < RandomReqs / 2) ? 12 : 24;
      if ($urandom_range(0, 99) < 80) page = page_pool[$urandom_range(0, pool_size - 1)];
      else page = 16'($urandom);
      act = ($urandom_range(0, 99) < 40) ? ACT_UPDATE : ACT_LOOKUP;
      send_request(act, page, 16'($urandom));
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then idle on to catch strays.
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (sb.error_count == 0 && sb.pending_rsp.size() == 0) begin
      $display("tlb_fifo_replacement_unit test passed");
    end else begin
      $display("tlb_fifo_replacement_unit test failed");
    end
    $finish;
  end

endmodule
